@@ hdl/lfst_pkg.sv @@
package lfst_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int POS_W  = 8;
  localparam int WORD_W = 2 * POS_W;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_BAD_REM   = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_FIND,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [SLOT_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] result_slot;
    logic [4:0] occupied_count;
    logic       has_free;
  } result_t;

endpackage

@@ hdl/lowest_free_slot_table_unit.sv @@
// lowest free slot table: sixteen slots, each holding a line and column position
// input stream s_*: one request per item, a command of insert, remove or find
// output stream m_*: exactly one result per request, in request order
// insert puts the position into the lowest free slot, remove frees a slot by
// index, find returns the lowest occupied slot holding the same position
// one request is in work at a time; s_tready is high only while idle
// after accept, remove, unused command and insert into a full table go straight
// to the finish state; insert walks the bitmap up to the lowest free slot k;
// find reads slot after slot until a match in slot k or the last slot, and each
// result then goes to the output register; the find scan is paced by the single
// read port of the position memory, one slot per cycle, and s_tready stays low
// reset clears the occupancy bitmap and count at once; positions of free slots
// are never read as valid, so the memory needs no clearing pass
// a stalled receiver holds the result in the output register; the next request
// is accepted meanwhile and its result waits until the register is taken
module lowest_free_slot_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // command[1:0] slot_index[5:2] entry_line[13:6] entry_col[21:14]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status[1:0] result_slot[5:2] occupied_count[10:6] has_free[11]
);

  lfst_pkg::ram_req_t                ram_req;
  logic [lfst_pkg::WORD_W-1:0]       ram_rdata;
  lfst_pkg::result_t                 res;
  logic                              res_valid;
  logic                              res_take;

  // sequencer and occupancy bitmap
  lfst_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .command    (s_tdata[1:0]),
    .slot_index (s_tdata[5:2]),
    .entry_line (s_tdata[13:6]),
    .entry_col  (s_tdata[21:14]),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  // stored positions, registered read
  lfst_slot_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // result register toward the receiver
  lfst_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

@@ hdl/lfst_slot_ram.sv @@
module lfst_slot_ram (
  input  logic                                clk,
  input  lfst_pkg::ram_req_t                  req,
  output logic [lfst_pkg::WORD_W-1:0]         rdata
);

  // line in the upper byte, column in the lower byte
  logic [lfst_pkg::WORD_W-1:0] mem [lfst_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

@@ hdl/lfst_ctrl.sv @@
module lfst_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        command,
  input  logic [3:0]                        slot_index,
  input  logic [lfst_pkg::POS_W-1:0]        entry_line,
  input  logic [lfst_pkg::POS_W-1:0]        entry_col,
  output lfst_pkg::ram_req_t                ram_req,
  input  logic [lfst_pkg::WORD_W-1:0]       ram_rdata,
  output logic                              res_valid,
  output lfst_pkg::result_t                 res,
  input  logic                              res_take
);

  localparam logic [lfst_pkg::SLOT_W-1:0] LAST_SLOT = lfst_pkg::SLOT_W'(lfst_pkg::SLOTS - 1);
  localparam logic [lfst_pkg::CNT_W-1:0]  FULL_CNT  = lfst_pkg::CNT_W'(lfst_pkg::SLOTS);

  lfst_pkg::state_t              state, state_next;
  logic [lfst_pkg::SLOTS-1:0]    occ, occ_next;
  logic [lfst_pkg::CNT_W-1:0]    count, count_next;
  logic [lfst_pkg::SLOT_W-1:0]   ptr, ptr_next;
  logic [lfst_pkg::SLOT_W-1:0]   rd_slot, rd_slot_next;
  logic                          rd_live, rd_live_next;
  logic [lfst_pkg::WORD_W-1:0]   key, key_next;
  lfst_pkg::result_t             res_next;
  logic [lfst_pkg::SLOT_W-1:0]   rem_sel;
  logic                          rem_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lfst_pkg::ST_IDLE;
      occ     <= '0;
      count   <= '0;
      rd_live <= 1'b0;
    end else begin
      state   <= state_next;
      occ     <= occ_next;
      count   <= count_next;
      rd_live <= rd_live_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    rd_slot <= rd_slot_next;
    key     <= key_next;
    res     <= res_next;
  end

  assign rem_sel = lfst_pkg::SLOT_W'(slot_index);
  assign rem_ok  = (int'(slot_index) < lfst_pkg::SLOTS) && occ[rem_sel];

  always_comb begin
    state_next   = state;
    occ_next     = occ;
    count_next   = count;
    ptr_next     = ptr;
    rd_slot_next = rd_slot;
    rd_live_next = rd_live;
    key_next     = key;
    res_next     = res;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = ptr;
    ram_req.wdata = key;
    ram_req.raddr = ptr;

    unique case (state)
      lfst_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_next = {entry_line, entry_col};
          ptr_next = '0;
          rd_live_next = 1'b0;
          res_next.status      = lfst_pkg::STAT_OK;
          res_next.result_slot = '0;
          res_next.occupied_count = 5'(count);
          res_next.has_free       = (count != FULL_CNT);
          unique case (command)
            lfst_pkg::CMD_INSERT: begin
              if (count == FULL_CNT) begin
                res_next.status = lfst_pkg::STAT_FULL;
                state_next = lfst_pkg::ST_FIN;
              end else begin
                state_next = lfst_pkg::ST_INSERT;
              end
            end
            lfst_pkg::CMD_REMOVE: begin
              if (rem_ok) begin
                occ_next[rem_sel] = 1'b0;
                count_next = count - 1'b1;
                res_next.occupied_count = 5'(count - 1'b1);
                res_next.has_free       = 1'b1;
              end else begin
                res_next.status = lfst_pkg::STAT_BAD_REM;
              end
              state_next = lfst_pkg::ST_FIN;
            end
            lfst_pkg::CMD_FIND: begin
              state_next = lfst_pkg::ST_FIND;
            end
            default: begin
              state_next = lfst_pkg::ST_FIN;
            end
          endcase
        end
      end

      lfst_pkg::ST_INSERT: begin
        // walk the bitmap upward; a free slot is known to exist
        if (!occ[ptr]) begin
          ram_req.we = 1'b1;
          occ_next[ptr] = 1'b1;
          count_next = count + 1'b1;
          res_next.result_slot    = 4'(ptr);
          res_next.occupied_count = 5'(count + 1'b1);
          res_next.has_free       = ((count + 1'b1) != FULL_CNT);
          state_next = lfst_pkg::ST_FIN;
        end else if (ptr != LAST_SLOT) begin
          ptr_next = ptr + 1'b1;
        end
      end

      lfst_pkg::ST_FIND: begin
        // read issued in the cycle before its compare
        if (rd_live && occ[rd_slot] && (ram_rdata == key)) begin
          res_next.result_slot = 4'(rd_slot);
          state_next = lfst_pkg::ST_FIN;
        end else if (rd_live && (rd_slot == LAST_SLOT)) begin
          res_next.status = lfst_pkg::STAT_NOT_FOUND;
          state_next = lfst_pkg::ST_FIN;
        end else begin
          rd_slot_next = ptr;
          rd_live_next = 1'b1;
          if (ptr != LAST_SLOT) begin
            ptr_next = ptr + 1'b1;
          end
        end
      end

      lfst_pkg::ST_FIN: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = lfst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = lfst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/lfst_out_reg.sv @@
module lfst_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  lfst_pkg::result_t res,
  output logic              res_take,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata
);

  assign res_take = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      m_tdata <= {4'b0, res.has_free, res.occupied_count, res.result_slot, res.status};
    end
  end

endmodule

@@ hdl/lfst_checker.sv @@
module lfst_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  localparam logic [4:0] FULL_CNT = 5'(lfst_pkg::SLOTS);

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in work");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // free flag agrees with the count
  a_free_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[10:6] <= FULL_CNT) && (m_tdata[11] == (m_tdata[10:6] != FULL_CNT))))
    else $error("count and free flag disagree");

  // full status only with a full table
  a_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[1:0] == lfst_pkg::STAT_FULL)) |-> (!m_tdata[11] && (m_tdata[5:2] == 4'd0)))
    else $error("full status with free slots");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind lowest_free_slot_table_unit lfst_checker u_lfst_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ sim/lfst_result_checker.sv @@
`timescale 1ns / 100ps

module lfst_result_checker
  import lfst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // command[1:0] slot_index[5:2] entry_line[13:6] entry_col[21:14]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // status[1:0] result_slot[5:2] occupied_count[10:6] has_free[11]
  output int          errors,
  output int          pending,
  output int          results_seen,
  output int          full_seen,
  output int          miss_seen,
  output int          bad_rem_seen
);

  // shadow of the slot store
  logic [SLOTS-1:0] occupied;
  logic [POS_W-1:0] held_line [SLOTS];
  logic [POS_W-1:0] held_col  [SLOTS];
  logic [CNT_W-1:0] in_use;

  result_t answers_due [$];
  result_t want;
  logic [1:0] got_status;
  logic [3:0] got_slot;
  logic [4:0] got_count;
  logic       got_free;

  // applies one request to the shadow store and returns its answer
  function automatic result_t apply_request(input logic [23:0] req);
    logic [1:0]       cmd;
    logic [3:0]       idx;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] col;
    result_t          r;
    bit               found;
    int               k;
    cmd   = req[1:0];
    idx   = req[5:2];
    line  = req[13:6];
    col   = req[21:14];
    r     = '0;
    found = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        r.status = STAT_FULL;
        for (k = 0; k < SLOTS; k++) begin
          if (!found && !occupied[k]) begin
            found         = 1'b1;
            occupied[k]   = 1'b1;
            held_line[k]  = line;
            held_col[k]   = col;
            in_use        = in_use + 1'b1;
            r.status      = STAT_OK;
            r.result_slot = 4'(k);
          end
        end
      end
      CMD_REMOVE: begin
        if (int'(idx) < SLOTS && occupied[idx] && in_use > 0) begin
          occupied[idx] = 1'b0;
          in_use        = in_use - 1'b1;
          r.status      = STAT_OK;
        end else begin
          r.status = STAT_BAD_REM;
        end
      end
      CMD_FIND: begin
        r.status = STAT_NOT_FOUND;
        for (k = 0; k < SLOTS; k++) begin
          if (!found && occupied[k] && held_line[k] == line && held_col[k] == col) begin
            found         = 1'b1;
            r.status      = STAT_OK;
            r.result_slot = 4'(k);
          end
        end
      end
      default: r.status = STAT_OK;
    endcase
    r.occupied_count = 5'(in_use);
    r.has_free       = (int'(in_use) < SLOTS);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      occupied     = '0;
      in_use       = '0;
      answers_due.delete();
      errors       = 0;
      pending      = 0;
      results_seen = 0;
      full_seen    = 0;
      miss_seen    = 0;
      bad_rem_seen = 0;
    end else begin
      // results always leave after their request is accepted, so check first
      if (m_tvalid && m_tready) begin
        results_seen++;
        got_status = m_tdata[1:0];
        got_slot   = m_tdata[5:2];
        got_count  = m_tdata[10:6];
        got_free   = m_tdata[11];
        if (answers_due.size() == 0) begin
          errors++;
          $error("result %h arrived with no request waiting", m_tdata);
        end else begin
          want = answers_due.pop_front();
          if (got_status !== want.status) begin
            errors++;
            $error("status: expected %0d, got %0d", want.status, got_status);
          end
          if (got_slot !== want.result_slot) begin
            errors++;
            $error("result_slot: expected %0d, got %0d", want.result_slot, got_slot);
          end
          if (got_count !== want.occupied_count) begin
            errors++;
            $error("occupied_count: expected %0d, got %0d", want.occupied_count, got_count);
          end
          if (got_free !== want.has_free) begin
            errors++;
            $error("has_free: expected %0d, got %0d", want.has_free, got_free);
          end
          if (want.status == STAT_FULL) full_seen++;
          if (want.status == STAT_NOT_FOUND) miss_seen++;
          if (want.status == STAT_BAD_REM) bad_rem_seen++;
        end
      end
      if (s_tvalid && s_tready) answers_due.push_back(apply_request(s_tdata));
      pending = answers_due.size();
    end
  end

endmodule

@@ sim/lowest_free_slot_table_unit_tb.sv @@
`timescale 1ns / 100ps

module lowest_free_slot_table_unit_tb;
  import lfst_pkg::*;

  localparam int RANDOM_REQUESTS = 800;
  localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no handshake on either side
  localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall, fills the block
  localparam int DRAIN_CYCLES    = 40;    // extra wait once every answer has been checked

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // command[1:0] slot_index[5:2] entry_line[13:6] entry_col[21:14]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // status[1:0] result_slot[5:2] occupied_count[10:6] has_free[11]

  int errors;
  int pending;
  int results_seen;
  int full_seen;
  int miss_seen;
  int bad_rem_seen;

  int phase = 1;            // 1: sender idles lightly, 2: receiver idles lightly, 3: no idling
  bit held_once = 1'b0;
  int quiet_cycles = 0;
  logic [15:0] recent_pos [$];   // {col, line} of recent inserts, to aim finds at hits

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  lowest_free_slot_table_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  lfst_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .full_seen    (full_seen),
    .miss_seen    (miss_seen),
    .bad_rem_seen (bad_rem_seen)
  );

  // idle odds in percent for each side, by phase
  function automatic int sender_idle_pct();
    case (phase)
      1: return 33;
      2: return 79;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (phase)
      1: return 79;
      2: return 33;
      default: return 0;
    endcase
  endfunction

  // offer one request, called at a falling edge, returns at a falling edge;
  // valid stays high across back-to-back requests
  task automatic send_request(input logic [1:0] cmd, input logic [3:0] idx,
                              input logic [7:0] line, input logic [7:0] col);
    while ($urandom_range(99) < sender_idle_pct()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, col, line, idx, cmd};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (cmd == CMD_INSERT) begin
      recent_pos.push_back({col, line});
      if (recent_pos.size() > SLOTS) void'(recent_pos.pop_front());
    end
  endtask

  // random traffic swings between filling and draining every 60 requests so
  // the table runs full and empty again; positions mostly come from a tiny
  // set so duplicates and hits are common
  task automatic random_request(input int n);
    logic [1:0]  cmd;
    logic [3:0]  idx;
    logic [7:0]  line;
    logic [7:0]  col;
    logic [15:0] pos;
    int          pick;
    bit          filling;
    filling = ((n / 60) % 2) == 0;
    pick    = $urandom_range(99);
    if (filling) begin
      cmd = (pick < 55) ? CMD_INSERT : (pick < 70) ? CMD_REMOVE :
            (pick < 95) ? CMD_FIND : CMD_NONE;
    end else begin
      cmd = (pick < 20) ? CMD_INSERT : (pick < 60) ? CMD_REMOVE :
            (pick < 95) ? CMD_FIND : CMD_NONE;
    end
    idx = 4'($urandom_range(15));
    if ($urandom_range(99) < 60) begin
      line = 8'($urandom_range(3));
      col  = 8'($urandom_range(3));
    end else begin
      line = 8'($urandom);
      col  = 8'($urandom);
    end
    // most finds look for something recently stored
    if (cmd == CMD_FIND && recent_pos.size() > 0 && $urandom_range(99) < 70) begin
      pos  = recent_pos[$urandom_range(recent_pos.size() - 1)];
      line = pos[7:0];
      col  = pos[15:8];
    end
    send_request(cmd, idx, line, col);
  endtask

  // receiver side: random stalls, plus one long hold-off when the no-idle
  // phase begins while the sender keeps pushing
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase == 3 && !held_once) begin
        held_once = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= receiver_idle_pct());
      end
    end
  end

  // watchdog: give up when nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("lowest_free_slot_table_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int         i;
    int         n;
    logic [7:0] line;
    logic [7:0] col;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill every slot first so no find ever scans an unwritten entry;
    // slot 0 gets the lowest position, slot 15 the highest, and slots 5 and 9
    // share one position
    for (i = 0; i < SLOTS; i++) begin
      if (i == 0) begin
        line = 8'h00;
        col  = 8'h00;
      end else if (i == SLOTS - 1) begin
        line = 8'hFF;
        col  = 8'hFF;
      end else if (i == 5 || i == 9) begin
        line = 8'h5A;
        col  = 8'hA5;
      end else begin
        line = 8'(i * 17);
        col  = ~8'(i * 17);
      end
      send_request(CMD_INSERT, 4'(i), line, col);
    end
    send_request(CMD_INSERT, 4'hF, 8'hFF, 8'h00);   // table full
    send_request(CMD_FIND,   4'h0, 8'h5A, 8'hA5);   // lowest of two matches
    send_request(CMD_REMOVE, 4'h5, 8'h00, 8'h00);
    send_request(CMD_FIND,   4'h0, 8'h5A, 8'hA5);   // freed slot must not match
    send_request(CMD_REMOVE, 4'h5, 8'hFF, 8'hFF);   // already free
    send_request(CMD_FIND,   4'hA, 8'hFF, 8'hFF);   // match in the top slot
    send_request(CMD_FIND,   4'h3, 8'h01, 8'h02);   // no match anywhere
    send_request(CMD_NONE,   4'hF, 8'hFF, 8'hFF);   // unused command
    send_request(CMD_INSERT, 4'h0, 8'h80, 8'h7F);   // reuses the freed slot

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      phase = (n < 300) ? 1 : (n < 550) ? 2 : 3;
      random_request(n);
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests through fill and drain swings: %0d full-table inserts,",
             results_seen, full_seen);
    $display("%0d finds without a match, %0d rejected removes, one %0d-cycle output stall",
             miss_seen, bad_rem_seen, HOLD_OFF_CYCLES);
    if (errors == 0) begin
      $display("lowest_free_slot_table_unit_tb: PASS");
    end else begin
      $display("lowest_free_slot_table_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
